FILE: hw/rtl/ptb_pkg.sv
// Shared types and constants of the periodic timer bank.
package ptb_pkg;

   localparam int IdWidth     = 6;
   localparam int TickWidth   = 32;
   localparam int PeriodWidth = 28;
   localparam int MsWidth     = 29;
   localparam int DriftWidth  = 21;
   localparam int AccumWidth  = 22;

   localparam logic [AccumWidth-1:0] InputClock = 22'd1193180;
   localparam logic [DriftWidth-1:0] DriftMax   = 21'd1193179;
   localparam logic [DriftWidth-1:0] DriftReset = 21'd3180;
   localparam logic [PeriodWidth-1:0] PeriodMax = {PeriodWidth{1'b1}};

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_SET_IVL = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_EXPIRY = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_FREE    = 3'd1,
      ST_BAD_IVL    = 3'd2,
      ST_BAD_ID     = 3'd3,
      ST_NOT_ACTIVE = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [IdWidth-1:0]      id;
      logic                    bad_id;
      logic                    zero_ms;
      logic [PeriodWidth-1:0]  period;
   } entry_type;

   typedef struct packed {
      logic [TickWidth-1:0]    last_fire;
      logic [PeriodWidth-1:0]  countdown;
      logic [PeriodWidth-1:0]  period;
   } timer_rec_type;

endpackage

FILE: hw/rtl/periodic_timer_bank.sv
// Periodic timer bank top level.
//
// Request channel (req_): one command per beat. req_tuser holds cmd (0 tick,
// 1 allocate, 2 release, 3 set interval); req_tdata holds timer_id and
// interval_ms. Result channel (rsp_): tuser holds kind, tlast marks the last
// result of a command. csr_ writes drift_increment (saturated).
// A front end classifies commands into a two-entry queue; the back end
// executes them one at a time against the link registers and the timer RAM.
// Allocate, release and set interval pass the back-end states S_IDLE and
// S_CMD; S_CMD loads the status beat into the output register.
// A tick walks the busy list, one RAM read and one RAM write per timer, with
// an expiry result for each timer whose countdown runs out.
// Expiry and tick-done divisions use a registered reciprocal multiplier.
// Reset empties the busy list, chains all timers on the free list,
// clears the tick count and loads the default drift. When the receiver
// stalls the result is held in the output register and the back end waits;
// the front keeps accepting until the queue is full.
module periodic_timer_bank
   import ptb_pkg::*;
#(
   parameter int TIMERS       = 32,
   parameter int TICKS_PER_MS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // timer_id, interval_ms
   input  logic [1:0]            req_tuser,   // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // status, result_id, elapsed_ms, ticks_ms
   output logic [1:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [DriftWidth-1:0] csr_data
);

   localparam int IW = TIMERS > 1 ? $clog2(TIMERS) : 1;

   logic          q_full, q_push, q_pop, q_not_empty;
   entry_type     push_entry, pop_entry;
   logic          div_start;
   logic [TickWidth-1:0] div_x;
   logic [MsWidth-1:0]   div_q;
   logic          ram_wen, ram_ren;
   logic [IW-1:0] ram_waddr, ram_raddr;
   timer_rec_type ram_wdata, ram_rdata;

   ptb_front #(.TIMERS(TIMERS), .TICKS_PER_MS(TICKS_PER_MS)) u_front (
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .q_full(q_full), .q_push(q_push), .q_entry(push_entry)
   );

   ptb_fifo #(.WIDTH($bits(entry_type))) u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_data(push_entry),
      .full(q_full), .pop(q_pop), .not_empty(q_not_empty), .pop_data(pop_entry)
   );

   ptb_div #(.TICKS_PER_MS(TICKS_PER_MS)) u_div (
      .clock(clock), .start(div_start), .x(div_x), .q(div_q)
   );

   ptb_ram #(.WIDTH($bits(timer_rec_type)), .DEPTH(TIMERS)) u_ram (
      .clock(clock), .wen(ram_wen), .waddr(ram_waddr), .wdata(ram_wdata),
      .ren(ram_ren), .raddr(ram_raddr), .rdata(ram_rdata)
   );

   ptb_back #(.TIMERS(TIMERS)) u_back (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .q_not_empty(q_not_empty), .q_entry(pop_entry), .q_pop(q_pop),
      .div_start(div_start), .div_x(div_x), .div_q(div_q),
      .ram_wen(ram_wen), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
      .ram_ren(ram_ren), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

endmodule

FILE: hw/rtl/ptb_ram.sv
// Generic single-port-write, registered-read RAM.
module ptb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wen,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      ren,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/ptb_fifo.sv
// Two-entry command queue between front and back.
module ptb_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/ptb_front.sv
// Front end: accepts request beats, classifies and scales the interval.
module ptb_front
   import ptb_pkg::*;
#(
   parameter int TIMERS       = 32,
   parameter int TICKS_PER_MS = 10
) (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        q_full,
   output logic        q_push,
   output entry_type   q_entry
);

   logic [7:0]  id;
   logic [23:0] ms;
   logic [33:0] prod;

   always_comb begin
      id   = req_tdata[7:0];
      ms   = req_tdata[31:8];
      prod = 34'(ms) * 34'(TICKS_PER_MS);
      q_entry.cmd     = cmd_type'(req_tuser);
      q_entry.id      = id[IdWidth-1:0];
      q_entry.bad_id  = id >= 8'(TIMERS);
      q_entry.zero_ms = ms == 24'd0;
      q_entry.period  = (prod > 34'(PeriodMax)) ? PeriodMax : prod[PeriodWidth-1:0];
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

FILE: hw/rtl/ptb_div.sv
// Divide by TICKS_PER_MS through a registered reciprocal multiply.
module ptb_div
   import ptb_pkg::*;
#(
   parameter int TICKS_PER_MS = 10
) (
   input  logic                 clock,
   input  logic                 start,
   input  logic [TickWidth-1:0] x,
   output logic [MsWidth-1:0]   q
);

   localparam int          Shift = $clog2(TICKS_PER_MS);
   localparam logic [63:0] Mul   = ((64'd1 << (32 + Shift)) / TICKS_PER_MS) + 64'd1;
   localparam logic [31:0] MulLo = Mul[31:0];

   logic [TickWidth-1:0] x_ff;
   logic [63:0]          prod_ff;
   logic [64:0]          sum;

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= x;
         prod_ff <= 64'(x) * 64'(MulLo);
      end
   end

   always_comb begin
      sum = {1'b0, x_ff, 32'd0} + {1'b0, prod_ff};
      q   = MsWidth'(sum >> (32 + Shift));
   end

endmodule

FILE: hw/rtl/ptb_back.sv
// Back end: list management, tick walk and result register.
module ptb_back
   import ptb_pkg::*;
#(
   parameter int TIMERS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [DriftWidth-1:0]   csr_data,
   input  logic                    q_not_empty,
   input  entry_type               q_entry,
   output logic                    q_pop,
   output logic                    div_start,
   output logic [TickWidth-1:0]    div_x,
   input  logic [MsWidth-1:0]      div_q,
   output logic                    ram_wen,
   output logic [(TIMERS > 1 ? $clog2(TIMERS) : 1)-1:0] ram_waddr,
   output timer_rec_type           ram_wdata,
   output logic                    ram_ren,
   output logic [(TIMERS > 1 ? $clog2(TIMERS) : 1)-1:0] ram_raddr,
   input  timer_rec_type           ram_rdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [71:0]             rsp_tdata,  // status, result_id, elapsed_ms, ticks_ms
   output logic [1:0]              rsp_tuser,  // kind
   output logic                    rsp_tlast
);

   localparam int IW = TIMERS > 1 ? $clog2(TIMERS) : 1;
   localparam int VW = $clog2(TIMERS + 1);
   localparam logic [IdWidth-1:0] None = IdWidth'(TIMERS);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_CMD  = 9'b000000010,
      S_TICK = 9'b000000100,
      S_RD   = 9'b000001000,
      S_UPD  = 9'b000010000,
      S_EXP  = 9'b000100000,
      S_FIN  = 9'b001000000,
      S_DONE = 9'b010000000,
      S_SPARE = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   entry_type              cmd_ff;
   logic [DriftWidth-1:0]  drift_ff;
   logic [TickWidth-1:0]   tick_ff;
   logic [AccumWidth-1:0]  accum_ff;
   logic [IdWidth-1:0]     free_head_ff, busy_head_ff, cur_ff;
   logic [VW-1:0]          visits_ff;
   logic [IdWidth-1:0]     next_ff [TIMERS];
   logic [IdWidth-1:0]     prev_ff [TIMERS];
   logic                   active_ff [TIMERS];

   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff;
   status_type             rsp_status_ff;
   logic [IdWidth-1:0]     rsp_id_ff;
   logic [MsWidth-1:0]     rsp_elapsed_ff, rsp_ticks_ff;
   logic                   rsp_last_ff;

   logic                   out_free;
   logic                   rsp_load;
   logic [AccumWidth-1:0]  acc_sum;
   logic                   carry;
   logic [PeriodWidth-1:0] cd_dec;
   logic [IW-1:0]          cur_idx, cmd_idx, free_idx;
   logic                   walk_end;
   logic                   is_active;
   logic [IdWidth-1:0]     rel_prev, rel_next, alloc_new_free;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      acc_sum   = accum_ff + AccumWidth'(drift_ff);
      carry     = acc_sum >= InputClock;
      cd_dec    = ram_rdata.countdown - 1'b1;
      cur_idx   = cur_ff[IW-1:0];
      cmd_idx   = cmd_ff.id[IW-1:0];
      free_idx  = free_head_ff[IW-1:0];
      walk_end  = cur_ff >= None || visits_ff == VW'(TIMERS);
      is_active = !cmd_ff.bad_id && active_ff[cmd_idx];
      rel_prev  = prev_ff[cmd_idx];
      rel_next  = next_ff[cmd_idx];
      alloc_new_free = next_ff[free_idx];
   end

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      rsp_load  = 1'b0;
      div_start = 1'b0;
      div_x     = tick_ff;
      ram_wen   = 1'b0;
      ram_waddr = cur_idx;
      ram_wdata = ram_rdata;
      ram_ren   = 1'b0;
      ram_raddr = cur_idx;
      unique case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop     = 1'b1;
               ram_ren   = 1'b1;
               ram_raddr = q_entry.id[IW-1:0];
               state_in  = (q_entry.cmd == CMD_TICK) ? S_TICK : S_CMD;
            end
         end
         S_CMD: begin
            if (out_free) begin
               state_in = S_IDLE;
               rsp_load = 1'b1;
               unique case (cmd_ff.cmd)
                  CMD_ALLOC: begin
                     if (free_head_ff < None && !cmd_ff.zero_ms) begin
                        ram_wen   = 1'b1;
                        ram_waddr = free_idx;
                        ram_wdata = '{last_fire: tick_ff, countdown: cmd_ff.period,
                                      period: cmd_ff.period};
                     end
                  end
                  CMD_RELEASE: begin
                     if (is_active) begin
                        ram_wen   = 1'b1;
                        ram_waddr = cmd_idx;
                        ram_wdata = '0;
                     end
                  end
                  CMD_SET_IVL: begin
                     if (is_active && !cmd_ff.zero_ms) begin
                        ram_wen   = 1'b1;
                        ram_waddr = cmd_idx;
                        ram_wdata.period = cmd_ff.period;
                        if (ram_rdata.countdown > cmd_ff.period) begin
                           ram_wdata.countdown = cmd_ff.period;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_TICK: state_in = S_RD;
         S_RD: begin
            if (walk_end) begin
               state_in = S_FIN;
            end else begin
               ram_ren  = 1'b1;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            ram_wen = 1'b1;
            if (cd_dec == '0) begin
               ram_wdata.countdown = ram_rdata.period;
               ram_wdata.last_fire = tick_ff;
               div_start = 1'b1;
               div_x     = tick_ff - ram_rdata.last_fire;
               state_in  = S_EXP;
            end else begin
               ram_wdata.countdown = cd_dec;
               state_in = S_RD;
            end
         end
         S_EXP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_RD;
            end
         end
         S_FIN: begin
            div_start = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         drift_ff     <= DriftReset;
         tick_ff      <= '0;
         accum_ff     <= '0;
         free_head_ff <= '0;
         busy_head_ff <= None;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TIMERS; i++) begin
            next_ff[i]   <= IdWidth'(i + 1);
            prev_ff[i]   <= (i == 0) ? None : IdWidth'(i - 1);
            active_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            drift_ff <= (csr_data > DriftMax) ? DriftMax : csr_data;
         end
         unique case (state_ff)
            S_CMD: begin
               if (out_free) begin
                  unique case (cmd_ff.cmd)
                     CMD_ALLOC: begin
                        if (free_head_ff < None && !cmd_ff.zero_ms) begin
                           free_head_ff <= alloc_new_free;
                           if (alloc_new_free < None) begin
                              prev_ff[alloc_new_free[IW-1:0]] <= None;
                           end
                           if (busy_head_ff < None) begin
                              prev_ff[busy_head_ff[IW-1:0]] <= free_head_ff;
                           end
                           next_ff[free_idx]   <= busy_head_ff;
                           prev_ff[free_idx]   <= None;
                           busy_head_ff        <= free_head_ff;
                           active_ff[free_idx] <= 1'b1;
                        end
                     end
                     CMD_RELEASE: begin
                        if (is_active) begin
                           if (rel_prev < None) begin
                              next_ff[rel_prev[IW-1:0]] <= rel_next;
                           end else begin
                              busy_head_ff <= rel_next;
                           end
                           if (rel_next < None) begin
                              prev_ff[rel_next[IW-1:0]] <= rel_prev;
                           end
                           if (free_head_ff < None) begin
                              prev_ff[free_idx] <= cmd_ff.id;
                           end
                           next_ff[cmd_idx]   <= free_head_ff;
                           prev_ff[cmd_idx]   <= None;
                           free_head_ff       <= cmd_ff.id;
                           active_ff[cmd_idx] <= 1'b0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_TICK: begin
               tick_ff   <= tick_ff + 32'd1 + 32'(carry);
               accum_ff  <= carry ? acc_sum - InputClock : acc_sum;
               cur_ff    <= busy_head_ff;
               visits_ff <= '0;
            end
            S_UPD: begin
               if (cd_dec != '0) begin
                  cur_ff    <= next_ff[cur_idx];
                  visits_ff <= visits_ff + 1'b1;
               end
            end
            S_EXP: begin
               if (out_free) begin
                  cur_ff       <= next_ff[cur_idx];
                  visits_ff    <= visits_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && q_not_empty) begin
         cmd_ff <= q_entry;
      end
      if (out_free) begin
         rsp_elapsed_ff <= '0;
         rsp_ticks_ff   <= '0;
         rsp_id_ff      <= '0;
         rsp_status_ff  <= ST_OK;
         unique case (state_ff)
            S_CMD: begin
               rsp_kind_ff <= KIND_STATUS;
               rsp_last_ff <= 1'b1;
               if (cmd_ff.cmd == CMD_ALLOC) begin
                  if (free_head_ff >= None) begin
                     rsp_status_ff <= ST_NO_FREE;
                  end else if (cmd_ff.zero_ms) begin
                     rsp_status_ff <= ST_BAD_IVL;
                  end else begin
                     rsp_id_ff <= free_head_ff;
                  end
               end else if (cmd_ff.bad_id) begin
                  rsp_status_ff <= ST_BAD_ID;
               end else if (!is_active) begin
                  rsp_status_ff <= ST_NOT_ACTIVE;
               end else if (cmd_ff.cmd == CMD_SET_IVL && cmd_ff.zero_ms) begin
                  rsp_status_ff <= ST_BAD_IVL;
               end
            end
            S_EXP: begin
               rsp_kind_ff    <= KIND_EXPIRY;
               rsp_last_ff    <= 1'b0;
               rsp_id_ff      <= cur_ff;
               rsp_elapsed_ff <= div_q;
            end
            S_DONE: begin
               rsp_kind_ff  <= KIND_DONE;
               rsp_last_ff  <= 1'b1;
               rsp_ticks_ff <= div_q;
            end
            default: ;
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_ticks_ff, rsp_elapsed_ff, rsp_id_ff, rsp_status_ff};

   assert property (@(posedge clock) disable iff (reset)
      (free_head_ff < None && busy_head_ff < None) |-> free_head_ff != busy_head_ff)
      else $error("free and busy lists share a head");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXP && $past(state_ff) != S_EXP) |-> $past(state_ff) == S_UPD)
      else $error("expiry without countdown update");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (cur_ff < None && visits_ff < VW'(TIMERS)))
      else $error("walk past list end");

endmodule
